### rtl/core/bqc_pkg.sv
// Package for the biquad cascade: beat types, coefficient set, register indexes
// and the rounding and saturation helpers that the sections use.
// Depends on nothing.
package bqc_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 24;
    localparam int COEF_FRAC = 22;
    localparam int STATE_W   = 48;
    localparam int CFG_IDX_W = 3;

    localparam int DEFAULT_NUM_SECTIONS = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FEED_ZERO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_ONE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_TWO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_ONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_TWO  = 3'd4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [STATE_W-1:0]  state_t;

    typedef struct packed {
        sample_t sample_in;
        logic    block_end;
    } in_beat_t;

    typedef struct packed {
        sample_t sample_out;
        logic    block_end_out;
    } out_beat_t;

    typedef struct packed {
        coef_t feed_zero;
        coef_t feed_one;
        coef_t feed_two;
        coef_t back_one;
        coef_t back_two;
    } coef_set_t;

    // Round to nearest (ties up) from the 2^-22 scale and saturate to a sample.
    function automatic sample_t round_sat_sample(input logic signed [STATE_W:0] acc);
        logic signed [STATE_W+1:0] biased;
        logic [STATE_W+1-COEF_FRAC:0] quot;
        sample_t result;
        biased = {acc[STATE_W], acc} + ((STATE_W+2)'(1) <<< (COEF_FRAC - 1));
        quot   = biased[STATE_W+1:COEF_FRAC];
        // The quotient fits when all bits above the sample's sign bit agree with it.
        if (quot[STATE_W+1-COEF_FRAC:SAMPLE_W-1] == '0 ||
            quot[STATE_W+1-COEF_FRAC:SAMPLE_W-1] == '1) begin
            result = quot[SAMPLE_W-1:0];
        end else if (quot[STATE_W+1-COEF_FRAC]) begin
            result = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return result;
    endfunction

    // Saturate a two-bit-guarded sum to the state width.
    function automatic state_t sat_state(input logic signed [STATE_W+1:0] v);
        state_t result;
        if (v[STATE_W+1:STATE_W-1] == '0 || v[STATE_W+1:STATE_W-1] == '1) begin
            result = v[STATE_W-1:0];
        end else if (v[STATE_W+1]) begin
            result = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return result;
    endfunction

endpackage

### rtl/core/bqc_section.sv
// One second-order section of the cascade, holding its own two delay states.
// Depends on bqc_pkg.
module bqc_section (
    input  logic              aclk,
    input  logic              aresetn,
    input  bqc_pkg::coef_set_t coef,
    input  logic              in_valid,
    output logic              in_ready,
    input  bqc_pkg::in_beat_t in_beat,
    output logic              out_valid,
    input  logic              out_ready,
    output bqc_pkg::in_beat_t out_beat
);
    import bqc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL_X  = 5'b00010,
        ST_SUM    = 5'b00100,
        ST_MUL_Y  = 5'b01000,
        ST_UPDATE = 5'b10000
    } phase_t;

    phase_t   phase_reg, phase_next;
    logic     out_valid_reg, out_valid_next;
    sample_t  x_reg;
    logic     end_reg;
    state_t   p0_reg, p1_reg, p2_reg;
    state_t   q1_reg, q2_reg;
    in_beat_t out_beat_reg;
    state_t   first_delay_reg, first_delay_next;
    state_t   second_delay_reg, second_delay_next;

    logic                      accept;
    logic                      out_free;
    logic signed [STATE_W:0]   acc;
    logic signed [STATE_W+1:0] first_sum;
    logic signed [STATE_W+1:0] second_sum;

    // A new beat may enter while the previous one finishes its state update.
    assign in_ready  = (phase_reg == ST_IDLE) || (phase_reg == ST_UPDATE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // Output accumulator and the state recurrences, all with guard bits.
    assign acc        = {p0_reg[STATE_W-1], p0_reg} + {first_delay_reg[STATE_W-1], first_delay_reg};
    assign first_sum  = {{2{p1_reg[STATE_W-1]}}, p1_reg} - {{2{q1_reg[STATE_W-1]}}, q1_reg}
                      + {{2{second_delay_reg[STATE_W-1]}}, second_delay_reg};
    assign second_sum = {{2{p2_reg[STATE_W-1]}}, p2_reg} - {{2{q2_reg[STATE_W-1]}}, q2_reg};

    // Phase sequencing; the sum phase waits while the output register is full.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            ST_IDLE:   if (accept) phase_next = ST_MUL_X;
            ST_MUL_X:  phase_next = ST_SUM;
            ST_SUM:    if (out_free) phase_next = ST_MUL_Y;
            ST_MUL_Y:  phase_next = ST_UPDATE;
            ST_UPDATE: phase_next = accept ? ST_MUL_X : ST_IDLE;
            default:   phase_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (phase_reg == ST_SUM && out_free) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        first_delay_next  = first_delay_reg;
        second_delay_next = second_delay_reg;
        if (phase_reg == ST_UPDATE) begin
            first_delay_next  = sat_state(first_sum);
            second_delay_next = sat_state(second_sum);
        end
    end

    // Control and delay states.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            first_delay_reg  <= '0;
            second_delay_reg <= '0;
        end else begin
            phase_reg        <= phase_next;
            out_valid_reg    <= out_valid_next;
            first_delay_reg  <= first_delay_next;
            second_delay_reg <= second_delay_next;
        end
    end

    // Datapath: input capture, feedforward products, output, feedback products.
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= in_beat.sample_in;
            end_reg <= in_beat.block_end;
        end
        if (phase_reg == ST_MUL_X) begin
            p0_reg <= coef.feed_zero * x_reg;
            p1_reg <= coef.feed_one * x_reg;
            p2_reg <= coef.feed_two * x_reg;
        end
        if (phase_reg == ST_SUM && out_free) begin
            out_beat_reg.sample_in <= round_sat_sample(acc);
            out_beat_reg.block_end <= end_reg;
        end
        if (phase_reg == ST_MUL_Y) begin
            q1_reg <= coef.back_one * out_beat_reg.sample_in;
            q2_reg <= coef.back_two * out_beat_reg.sample_in;
        end
    end

endmodule

### rtl/core/biquad_cascade_filter.sv
// Biquad cascade top level: coefficient registers and a chain of bqc_section cells; uses bqc_pkg.
// Each section registers its input, feedforward products, rounded output (waiting while that
// register is full) and feedback products, then updates its states and can accept the next one.
// Reset (aresetn low, synchronous): coefficients and all delay states clear to zero.
// The output register of the last section holds a finished beat while new input is taken.
module biquad_cascade_filter #(
    parameter int NUM_SECTIONS = bqc_pkg::DEFAULT_NUM_SECTIONS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bqc_pkg::in_beat_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bqc_pkg::out_beat_t                 m_data,
    input  logic                               cfg_wr_en,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bqc_pkg::COEF_W-1:0]         cfg_data
);
    import bqc_pkg::*;

    coef_set_t coef_reg, coef_next;

    logic     link_valid [NUM_SECTIONS+1];
    logic     link_ready [NUM_SECTIONS+1];
    in_beat_t link_beat  [NUM_SECTIONS+1];

    // Coefficient write decode; writes beyond the list are dropped.
    always_comb begin
        coef_next = coef_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FEED_ZERO: coef_next.feed_zero = cfg_data;
                REG_FEED_ONE:  coef_next.feed_one  = cfg_data;
                REG_FEED_TWO:  coef_next.feed_two  = cfg_data;
                REG_BACK_ONE:  coef_next.back_one  = cfg_data;
                REG_BACK_TWO:  coef_next.back_two  = cfg_data;
                default:       coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

    // Ends of the chain.
    assign link_valid[0]            = s_valid;
    assign s_ready                  = link_ready[0];
    assign link_beat[0]             = s_data;
    assign m_valid                  = link_valid[NUM_SECTIONS];
    assign link_ready[NUM_SECTIONS] = m_ready;
    assign m_data.sample_out        = link_beat[NUM_SECTIONS].sample_in;
    assign m_data.block_end_out     = link_beat[NUM_SECTIONS].block_end;

    // One cell per section, each handing its output beat to the next.
    for (genvar i = 0; i < NUM_SECTIONS; i++) begin : g_section
        bqc_section u_section (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .coef      (coef_reg),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_beat   (link_beat[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_beat  (link_beat[i+1])
        );
    end

endmodule

### verif/tb_biquad_cascade_filter.sv
// Self-checking testbench for the biquad cascade filter: stimulus, coefficient loads and a
// bit-exact predictor of the section chain whose results are compared beat by beat.
// Depends on bqc_pkg and biquad_cascade_filter.
`timescale 1ns / 1ps

module tb_biquad_cascade_filter;
    import bqc_pkg::*;

    localparam int SECTIONS        = DEFAULT_NUM_SECTIONS;
    localparam int SETTLE_CYCLES   = 2 * SECTIONS + 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_SAMPLES   = 100;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam coef_t   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam coef_t   COEF_ONE   = coef_t'(1) <<< COEF_FRAC;
    localparam coef_t   COEF_HALF  = coef_t'(1) <<< (COEF_FRAC - 1);

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_SPARSE
    } sink_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_beat_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_beat_t  m_data;
    logic       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data = '0;

    // Predictor state: coefficient copy and the delay line of every section.
    coef_set_t  coef_copy;
    state_t     delay_one [SECTIONS];
    state_t     delay_two [SECTIONS];

    out_beat_t  pending_out_q[$];
    int         error_count = 0;
    int         out_beats = 0;
    int         idle_cycles = 0;

    // Sender and receiver behavior, set by the tests.
    logic       src_bursty = 1'b0;
    int         burst_left = 0;
    sink_mode_t sink_mode = SINK_ALWAYS;
    int         hold_requests = 0;
    int         holds_done = 0;
    int         hold_count = 0;

    biquad_cascade_filter #(
        .NUM_SECTIONS(SECTIONS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clamp a wide value to a signed range of the given width.
    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Run one sample through every section, updating the delay lines.
    function automatic sample_t filter_sample(input sample_t x_in);
        longint x;
        longint acc;
        longint y;
        longint b0, b1, b2, a1, a2;
        int s;
        b0 = longint'(coef_copy.feed_zero);
        b1 = longint'(coef_copy.feed_one);
        b2 = longint'(coef_copy.feed_two);
        a1 = longint'(coef_copy.back_one);
        a2 = longint'(coef_copy.back_two);
        x = longint'(x_in);
        for (s = 0; s < SECTIONS; s++) begin
            acc = b0 * x + longint'(delay_one[s]);
            // Round to nearest with ties upward, then clamp to a sample.
            y = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
            y = clamp(y, SAMPLE_W);
            delay_one[s] = state_t'(clamp(b1 * x - a1 * y + longint'(delay_two[s]), STATE_W));
            delay_two[s] = state_t'(clamp(b2 * x - a2 * y, STATE_W));
            x = y;
        end
        return sample_t'(x);
    endfunction

    // Mostly full-range samples, with extremes and small values mixed in.
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return sample_t'($urandom_range(0, 510)) - sample_t'(255);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Coefficients of a stable section: |a2| < 1 and |a1| < 1 + a2.
    function automatic coef_set_t stable_coefs();
        coef_set_t c;
        int a2;
        int a1_mag;
        a2 = $urandom_range(0, 3774873);
        a1_mag = int'((longint'(4194304 + a2) * 95) / 100);
        c.back_two  = coef_t'(a2);
        c.back_one  = coef_t'($urandom_range(0, a1_mag));
        c.feed_zero = coef_t'($urandom_range(0, 4194304));
        c.feed_one  = coef_t'($urandom_range(0, 4194304));
        c.feed_two  = coef_t'($urandom_range(0, 4194304));
        if ($urandom_range(0, 1)) c.back_one  = -c.back_one;
        if ($urandom_range(0, 1)) c.feed_zero = -c.feed_zero;
        if ($urandom_range(0, 1)) c.feed_one  = -c.feed_one;
        if ($urandom_range(0, 1)) c.feed_two  = -c.feed_two;
        return c;
    endfunction

    // Write one coefficient register; the enable drops again after each write.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input coef_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FEED_ZERO: coef_copy.feed_zero = val;
            REG_FEED_ONE:  coef_copy.feed_one  = val;
            REG_FEED_TWO:  coef_copy.feed_two  = val;
            REG_BACK_ONE:  coef_copy.back_one  = val;
            REG_BACK_TWO:  coef_copy.back_two  = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic program_coefs(input coef_set_t c);
        cfg_write(REG_FEED_ZERO, c.feed_zero);
        cfg_write(REG_FEED_ONE,  c.feed_one);
        cfg_write(REG_FEED_TWO,  c.feed_two);
        cfg_write(REG_BACK_ONE,  c.back_one);
        cfg_write(REG_BACK_TWO,  c.back_two);
    endtask

    // Offer one input beat, wait for the handshake and record the predicted output.
    task automatic send_sample(input sample_t smp, input logic last);
        in_beat_t  beat;
        out_beat_t want;
        beat.sample_in = smp;
        beat.block_end = last;
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        want.sample_out    = filter_sample(smp);
        want.block_end_out = last;
        pending_out_q.push_back(want);
        // Bursts of random length separated by random gaps.
        if (src_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Let every predicted beat arrive, then give the pipeline time to settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_out_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random blocks of samples, the last of each block carrying the end mark.
    task automatic send_blocks(input int count);
        int left;
        int i;
        for (i = 0; i < count; i++) begin
            if (left == 0 || i == 0) left = $urandom_range(1, 32);
            left--;
            send_sample(random_sample(), left == 0 || i == count - 1);
        end
    endtask

    // Coefficients are all zero after reset, so every output is zero.
    task automatic test_reset_coefficients();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(1), 1'b1);
        wait_drained();
    endtask

    // Unity gain in both sections passes samples through unchanged.
    task automatic test_passthrough();
        coef_set_t c;
        c = '0;
        c.feed_zero = COEF_ONE;
        program_coefs(c);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b1);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(1), 1'b1);
        wait_drained();
    endtask

    // Extreme coefficients drive the section outputs and the delay states into saturation.
    task automatic test_saturation();
        coef_set_t c;
        c.feed_zero = COEF_MAX;
        c.feed_one  = COEF_MAX;
        c.feed_two  = COEF_MAX;
        c.back_one  = COEF_MIN;
        c.back_two  = COEF_MIN;
        program_coefs(c);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        wait_drained();
        c.feed_zero = COEF_MIN;
        c.feed_one  = COEF_MIN;
        c.feed_two  = COEF_MIN;
        c.back_one  = COEF_MAX;
        c.back_two  = COEF_MAX;
        program_coefs(c);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b1);
        wait_drained();
    endtask

    // A gain of one half puts odd samples exactly on a rounding tie, which goes upward.
    task automatic test_rounding_ties();
        coef_set_t c;
        c = '0;
        c.feed_zero = COEF_HALF;
        program_coefs(c);
        send_sample(sample_t'(1), 1'b0);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(3), 1'b0);
        send_sample(sample_t'(-3), 1'b1);
        wait_drained();
    endtask

    // Writes to indexes past the last register must leave the coefficients alone.
    task automatic test_ignored_indexes();
        logic [CFG_IDX_W-1:0] idx;
        // Walk from the first unused index up to the wrap of the index field.
        for (idx = REG_BACK_TWO + 1'b1; idx != '0; idx++) begin
            cfg_write(idx, coef_t'($urandom));
        end
        send_sample(sample_t'(5), 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        wait_drained();
    endtask

    // Several random coefficient sets with random traffic on both sides; states
    // carry over the end marks. The last set uses fully random coefficients.
    task automatic test_random_filters();
        coef_set_t c;
        int phase;
        src_bursty = 1'b1;
        sink_mode  = SINK_RANDOM;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1) begin
                c = coef_set_t'({$urandom, $urandom, $urandom, $urandom});
            end else begin
                c = stable_coefs();
            end
            program_coefs(c);
            send_blocks(PHASE_SAMPLES);
            wait_drained();
        end
    endtask

    // Full rate on both sides with no idling at all.
    task automatic test_full_rate();
        src_bursty = 1'b0;
        sink_mode  = SINK_ALWAYS;
        program_coefs(stable_coefs());
        send_blocks(60);
        wait_drained();
    endtask

    // The receiver stops for a long stretch while input keeps coming, so the
    // pipeline fills and the input stalls.
    task automatic test_back_pressure();
        src_bursty = 1'b0;
        sink_mode  = SINK_ALWAYS;
        hold_requests <= hold_requests + 1;
        send_blocks(40);
        wait_drained();
    endtask

    // A receiver that is ready only now and then, against a bursty sender.
    task automatic test_sparse_sink();
        src_bursty = 1'b1;
        sink_mode  = SINK_SPARSE;
        program_coefs(stable_coefs());
        send_blocks(60);
        wait_drained();
    endtask

    // Receiver: a long hold when asked, otherwise the current stall pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_count != 0) begin
            m_ready    <= 1'b0;
            hold_count <= hold_count - 1;
        end else if (holds_done != hold_requests) begin
            m_ready    <= 1'b0;
            hold_count <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            case (sink_mode)
                SINK_ALWAYS: m_ready <= 1'b1;
                SINK_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default:     m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare every output beat with the oldest prediction.
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_out_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("ERROR: unexpected output beat %0d: sample=%0d end=%0b",
                             out_beats, m_data.sample_out, m_data.block_end_out);
                end
            end else begin
                want = pending_out_q.pop_front();
                if (m_data.sample_out !== want.sample_out ||
                    m_data.block_end_out !== want.block_end_out) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("ERROR: beat %0d: expected %0d/%0b, got %0d/%0b",
                                 out_beats, want.sample_out, want.block_end_out,
                                 m_data.sample_out, m_data.block_end_out);
                    end
                end
            end
            out_beats++;
        end
    end

    // Count cycles in which nothing moves on any port.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("ERROR: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("biquad_cascade_filter verification failed");
        $finish;
    end

    initial begin
        int s;
        coef_copy = '0;
        for (s = 0; s < SECTIONS; s++) begin
            delay_one[s] = '0;
            delay_two[s] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_coefficients();
        test_passthrough();
        test_saturation();
        test_rounding_ties();
        test_ignored_indexes();
        test_random_filters();
        test_full_rate();
        test_back_pressure();
        test_sparse_sink();

        if (error_count == 0 && pending_out_q.size() == 0) begin
            $display("biquad_cascade_filter verification clean");
        end else begin
            $display("biquad_cascade_filter verification failed");
        end
        $finish;
    end

endmodule
